// ===== hdl/s2rgb_pkg.sv =====
// Shared types and palette constants for the scalar to RGB color map.
`default_nettype none

package s2rgb_pkg;

  // Configuration register index.
  typedef enum logic {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } reg_index_t;

  // Classification of one item, made at the front and carried to the output.
  typedef struct packed {
    logic flat;    // range_high not above range_low
    logic bright;  // sample above range_high (flat range only)
    logic neg;     // sample below range_low
  } item_flags_t;

  // Ramp slope: 4 * 255.
  localparam int SLOPE = 1020;

  // Ramp breakpoints in units of 1/255 (scaled by the fraction width downstream).
  localparam int RED_RISE   = 389;
  localparam int RED_FALL   = 1155;
  localparam int GRN_A_RISE = 133;
  localparam int GRN_A_FALL = 644;
  localparam int GRN_B_RISE = 392;
  localparam int GRN_B_FALL = 900;
  localparam int BLU_RISE   = -127;
  localparam int BLU_FALL   = 640;

  localparam logic [7:0] CHAN_MAX = 8'd255;
  localparam logic [7:0] CHAN_MIN = 8'd0;

endpackage

`default_nettype wire

// ===== hdl/s2rgb_queue.sv =====
// Small register FIFO between the front and the back of the color map.
`default_nettype none

module s2rgb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  logic do_push;
  logic do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/s2rgb_front.sv =====
// Front end: takes an item, classifies it against the range and forms the divide operands.
`default_nettype none

module s2rgb_front #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic [SAMPLE_WIDTH-1:0] range_low,
  input  wire logic [SAMPLE_WIDTH-1:0] range_high,
  output logic                         out_valid,
  output s2rgb_pkg::item_flags_t       out_flags,
  output logic [SAMPLE_WIDTH-1:0]      out_mag,
  output logic [SAMPLE_WIDTH-1:0]      out_den,
  input  wire logic                    out_ready
);

  import s2rgb_pkg::*;

  localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Offset binary: unsigned order matches signed order.
  logic [SAMPLE_WIDTH-1:0] s_ofs;
  logic [SAMPLE_WIDTH-1:0] lo_ofs;
  logic [SAMPLE_WIDTH-1:0] hi_ofs;
  item_flags_t             flags_next;
  logic [SAMPLE_WIDTH-1:0] mag_next;
  logic [SAMPLE_WIDTH-1:0] den_next;
  logic                    load;
  logic                    drain;

  always_comb begin
    s_ofs             = sample ^ SIGN_BIT;
    lo_ofs            = range_low ^ SIGN_BIT;
    hi_ofs            = range_high ^ SIGN_BIT;
    flags_next.flat   = (hi_ofs <= lo_ofs);
    flags_next.bright = (s_ofs > hi_ofs);
    flags_next.neg    = (s_ofs < lo_ofs);
    mag_next          = flags_next.neg ? (lo_ofs - s_ofs) : (s_ofs - lo_ofs);
    den_next          = hi_ofs - lo_ofs;
  end

  assign drain = out_valid && out_ready;
  assign busy  = out_valid && !out_ready;
  assign load  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_flags <= flags_next;
      out_mag   <= mag_next;
      out_den   <= den_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/s2rgb_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then saturation to signed x.
`default_nettype none

module s2rgb_div #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire s2rgb_pkg::item_flags_t  in_flags,
  input  wire logic [SAMPLE_WIDTH-1:0] in_mag,
  input  wire logic [SAMPLE_WIDTH-1:0] in_den,
  output logic                         out_valid,
  output s2rgb_pkg::item_flags_t       out_flags,
  output logic signed [FRACTION_BITS+1:0] out_x
);

  import s2rgb_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int XW = F + 2;

  localparam logic [XW-1:0] ONE_T   = XW'(1) << F;
  localparam logic [XW-1:0] TWO_T   = XW'(2) << F;
  localparam logic [XW-1:0] X_MAX   = TWO_T - XW'(1);
  localparam logic [XW-1:0] X_MIN   = XW'(0) - ONE_T;

  // Stage k holds the quotient after k fraction bits.
  logic        stg_valid [F+1];
  item_flags_t stg_flags [F+1];
  logic        stg_over  [F+1];
  logic [W-1:0] stg_den  [F+1];
  logic [W-1:0] stg_rem  [F+1];
  logic [F:0]   stg_quot [F+1];

  // Stage 0: integer part (0, 1 or saturated).
  logic         over0;
  logic         qbit0;
  logic [W-1:0] rem0;

  always_comb begin
    over0 = ({1'b0, in_mag} >= {in_den, 1'b0});
    qbit0 = (in_mag >= in_den);
    rem0  = qbit0 ? (in_mag - in_den) : in_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else begin
      stg_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stg_flags[0] <= in_flags;
    stg_over[0]  <= over0;
    stg_den[0]   <= in_den;
    stg_rem[0]   <= rem0;
    stg_quot[0]  <= {{F{1'b0}}, qbit0};
  end

  for (genvar k = 1; k <= F; k++) begin : g_bit
    logic [W:0]   rem2;
    logic         qbit;
    logic [W-1:0] rem_next;

    always_comb begin
      rem2     = {stg_rem[k-1], 1'b0};
      qbit     = (rem2 >= {1'b0, stg_den[k-1]});
      rem_next = qbit ? W'(rem2 - {1'b0, stg_den[k-1]}) : W'(rem2);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else begin
        stg_valid[k] <= stg_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      stg_flags[k] <= stg_flags[k-1];
      stg_over[k]  <= stg_over[k-1];
      stg_den[k]   <= stg_den[k-1];
      stg_rem[k]   <= rem_next;
      stg_quot[k]  <= {stg_quot[k-1][F-1:0], qbit};
    end
  end

  // Saturate to [-1, 2) and apply the sign.
  logic [XW-1:0] t_mag;
  logic [XW-1:0] x_next;

  always_comb begin
    t_mag = stg_over[F] ? TWO_T : {1'b0, stg_quot[F]};
    if (stg_flags[F].neg) begin
      x_next = (t_mag > ONE_T) ? X_MIN : (XW'(0) - t_mag);
    end else begin
      x_next = (t_mag >= TWO_T) ? X_MAX : t_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= stg_valid[F];
    end
  end

  always_ff @(posedge clk) begin
    out_flags <= stg_flags[F];
    out_x     <= signed'(x_next);
  end

endmodule

`default_nettype wire

// ===== hdl/s2rgb_shade.sv =====
// Palette back end: scales x, evaluates the channel ramps and clamps to 8 bits.
`default_nettype none

module s2rgb_shade #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire s2rgb_pkg::item_flags_t      in_flags,
  input  wire logic signed [FRACTION_BITS+1:0] in_x,
  output logic                             done,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue
);

  import s2rgb_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int VW = F + 14;

  localparam logic signed [11:0]   SLOPE_S = 12'(SLOPE);
  localparam logic signed [VW-1:0] K_RED_R = VW'(RED_RISE) <<< F;
  localparam logic signed [VW-1:0] K_RED_F = VW'(RED_FALL) <<< F;
  localparam logic signed [VW-1:0] K_GA_R  = VW'(GRN_A_RISE) <<< F;
  localparam logic signed [VW-1:0] K_GA_F  = VW'(GRN_A_FALL) <<< F;
  localparam logic signed [VW-1:0] K_GB_R  = VW'(GRN_B_RISE) <<< F;
  localparam logic signed [VW-1:0] K_GB_F  = VW'(GRN_B_FALL) <<< F;
  localparam logic signed [VW-1:0] K_BLU_R = VW'(BLU_RISE) <<< F;
  localparam logic signed [VW-1:0] K_BLU_F = VW'(BLU_FALL) <<< F;

  function automatic logic signed [VW-1:0] vmin(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Negative clamps to 0, integer part above 255 clamps to 255.
  function automatic logic [7:0] to_chan(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] ipart;
    ipart = v >>> F;
    if (v < 0) begin
      return CHAN_MIN;
    end else if (ipart > VW'(CHAN_MAX)) begin
      return CHAN_MAX;
    end else begin
      return ipart[7:0];
    end
  endfunction

  // Stage A: x4 = 1020 * x.
  logic                 a_valid;
  item_flags_t          a_flags;
  logic signed [VW-1:0] a_x4;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_flags <= in_flags;
    a_x4    <= in_x * SLOPE_S;
  end

  // Stage B: ramps and clamping.
  logic signed [VW-1:0] red_v;
  logic signed [VW-1:0] grn_a;
  logic signed [VW-1:0] grn_b;
  logic signed [VW-1:0] grn_v;
  logic signed [VW-1:0] blu_v;
  logic [7:0]           flat_c;
  logic [7:0]           red_next;
  logic [7:0]           green_next;
  logic [7:0]           blue_next;

  always_comb begin
    red_v  = vmin(a_x4 - K_RED_R, K_RED_F - a_x4);
    grn_a  = vmin(a_x4 - K_GA_R, K_GA_F - a_x4);
    grn_b  = vmin(a_x4 - K_GB_R, K_GB_F - a_x4);
    grn_v  = (grn_a > grn_b) ? grn_a : grn_b;
    blu_v  = vmin(a_x4 - K_BLU_R, K_BLU_F - a_x4);
    flat_c = a_flags.bright ? CHAN_MAX : CHAN_MIN;
    if (a_flags.flat) begin
      red_next   = flat_c;
      green_next = flat_c;
      blue_next  = flat_c;
    end else begin
      red_next   = to_chan(red_v);
      green_next = to_chan(grn_v);
      blue_next  = to_chan(blu_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

`default_nettype wire

// ===== hdl/scalar_to_rgb_palette_top.sv =====
// Top level of the scalar to RGB false-color map.
`default_nettype none

// Maps one signed scalar sample per item to an RGB triple. The sample is
// normalized against range_low/range_high to a fixed-point x in [-1, 2) with
// FRACTION_BITS fraction bits, then run through a piecewise-linear palette
// (blue, cyan, green, yellow, red). If range_high is not above range_low, all
// channels are 255 for a sample above range_high and 0 otherwise.
// Rate: one item per clock, every clock; busy stays low in normal use since
// the result side never stalls. From the start edge to the done cycle an
// item passes the front register, the two-entry queue, the pipelined divider
// (one quotient bit per stage), its saturation stage and the two palette
// stages. Each result is on red/green/blue for exactly one cycle with done
// high; the receiver cannot hold it off. Range registers are written through
// wr_en/wr_index/wr_data and must only change while no item is in flight.
module scalar_to_rgb_palette_top #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                    wr_en,
  input  wire s2rgb_pkg::reg_index_t   wr_index,
  input  wire logic [SAMPLE_WIDTH-1:0] wr_data,
  output logic                         done,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue
);

  import s2rgb_pkg::*;

  localparam int FLAG_W  = $bits(item_flags_t);
  localparam int QW      = FLAG_W + 2 * SAMPLE_WIDTH;
  localparam logic [SAMPLE_WIDTH-1:0] HIGH_RESET = SAMPLE_WIDTH'(65536);

  // Range registers.
  logic [SAMPLE_WIDTH-1:0] range_low;
  logic [SAMPLE_WIDTH-1:0] range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= HIGH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_RANGE_LOW:  range_low  <= wr_data;
        REG_RANGE_HIGH: range_high <= wr_data;
        default: ;
      endcase
    end
  end

  // Front: classify and form operands.
  logic                    f_valid;
  item_flags_t             f_flags;
  logic [SAMPLE_WIDTH-1:0] f_mag;
  logic [SAMPLE_WIDTH-1:0] f_den;
  logic                    q_full;
  logic                    q_empty;
  logic [QW-1:0]           q_data;

  s2rgb_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample     (sample),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (f_valid),
    .out_flags  (f_flags),
    .out_mag    (f_mag),
    .out_den    (f_den),
    .out_ready  (!q_full)
  );

  // Queue between front and back; the back drains it every cycle.
  s2rgb_queue #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data ({f_flags, f_mag, f_den}),
    .full      (q_full),
    .pop       (!q_empty),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  item_flags_t             b_flags;
  logic [SAMPLE_WIDTH-1:0] b_mag;
  logic [SAMPLE_WIDTH-1:0] b_den;

  assign b_flags = item_flags_t'(q_data[QW-1 -: FLAG_W]);
  assign b_mag   = q_data[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
  assign b_den   = q_data[SAMPLE_WIDTH-1:0];

  // Back: divide, then palette.
  logic                           d_valid;
  item_flags_t                    d_flags;
  logic signed [FRACTION_BITS+1:0] d_x;

  s2rgb_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_flags  (b_flags),
    .in_mag    (b_mag),
    .in_den    (b_den),
    .out_valid (d_valid),
    .out_flags (d_flags),
    .out_x     (d_x)
  );

  s2rgb_shade #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_shade (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_flags (d_flags),
    .in_x     (d_x),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

`default_nettype wire

// ===== tb/tb_scalar_to_rgb_palette_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the scalar to RGB false-color map: directed and random items.

module tb_scalar_to_rgb_palette_top;
  import s2rgb_pkg::*;

  localparam int SW = 32;              // sample and range width
  localparam int FB = 16;              // fraction bits of the normalized x
  localparam int LATENCY = FB + 5;     // start edge to done cycle
  localparam int STALL_LIMIT = 1000;   // cycles with no item in or out before giving up

  localparam longint ONE = longint'(1) << FB;
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] S_MAX = ~S_MIN;

  // Palette: ramps of slope 4 (x 255), breakpoints in 1/255 steps.
  localparam longint RAMP_GAIN = 1020;
  localparam longint R_UP  = 389;
  localparam longint R_DN  = 1155;
  localparam longint GA_UP = 133;
  localparam longint GA_DN = 644;
  localparam longint GB_UP = 392;
  localparam longint GB_DN = 900;
  localparam longint B_UP  = -127;
  localparam longint B_DN  = 640;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // One pending color: the sample that caused it, kept for the mismatch text.
  typedef struct packed {
    logic [SW-1:0] smp;
    rgb_t          color;
  } color_item_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [SW-1:0] sample;
  logic          wr_en;
  reg_index_t    wr_index;
  logic [SW-1:0] wr_data;
  logic          done;
  logic [7:0]    red;
  logic [7:0]    green;
  logic [7:0]    blue;

  // Shadow copy of the range registers as the DUT holds them.
  logic [SW-1:0] cur_low;
  logic [SW-1:0] cur_high;

  color_item_t pending_colors[$];   // colors owed by the DUT, oldest first
  int send_idle_pct;                // chance in percent that the sender idles a cycle
  int fail_count = 0;
  int stall_cycles = 0;

  scalar_to_rgb_palette_top #(
    .SAMPLE_WIDTH (SW),
    .FRACTION_BITS(FB)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .sample  (sample),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Color predictor
  // ---------------------------------------------------------------------------

  function automatic longint min_l(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint max_l(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // 255*y in Q.FB -> 8-bit channel, truncated and clamped.
  function automatic logic [7:0] to_channel(input longint v);
    longint q;
    if (v < 0) return 8'd0;
    q = v >>> FB;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rgb_t predict_color(input logic [SW-1:0] smp,
                                         input logic [SW-1:0] lo,
                                         input logic [SW-1:0] hi);
    logic [SW-1:0]   so;
    logic [SW-1:0]   lo_o;
    logic [SW-1:0]   hi_o;
    logic            below;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned t;
    longint          x;
    longint          x4;
    rgb_t            c;
    // Flip the sign bit so unsigned compares order signed values.
    so   = smp ^ S_MIN;
    lo_o = lo ^ S_MIN;
    hi_o = hi ^ S_MIN;
    // Empty or inverted range: a plain threshold at range_high.
    if (hi_o <= lo_o) begin
      c.r = (so > hi_o) ? 8'd255 : 8'd0;
      c.g = c.r;
      c.b = c.r;
      return c;
    end
    den   = 64'(hi_o) - 64'(lo_o);
    below = so < lo_o;
    mag   = below ? 64'(lo_o) - 64'(so) : 64'(so) - 64'(lo_o);
    // |x| in Q.FB, truncated toward zero; fits easily since mag < 2^SW.
    t = (mag << FB) / den;
    // Saturate to [-1, 2 - 1 lsb].
    if (below) x = (t > 64'(ONE)) ? -ONE : -longint'(t);
    else x = (t >= 64'(2 * ONE)) ? 2 * ONE - 1 : longint'(t);
    x4 = RAMP_GAIN * x;
    c.r = to_channel(min_l(x4 - R_UP * ONE, R_DN * ONE - x4));
    c.g = to_channel(max_l(min_l(x4 - GA_UP * ONE, GA_DN * ONE - x4),
                           min_l(x4 - GB_UP * ONE, GB_DN * ONE - x4)));
    c.b = to_channel(min_l(x4 - B_UP * ONE, B_DN * ONE - x4));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (fail_count < 50) $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  // Offer one item; it is taken at the first rising edge with busy low. start
  // stays high on return so back-to-back items need no extra NBA on it.
  task automatic send_sample(input logic [SW-1:0] v);
    color_item_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    sample <= v;
    do @(posedge clk); while (busy);
    entry.smp   = v;
    entry.color = predict_color(v, cur_low, cur_high);
    pending_colors.push_back(entry);
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed color has come out.
  task automatic drain_items();
    start <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the pipe empty. The trailing cycle keeps wr_en
  // from being lowered and raised in one step on back-to-back writes.
  task automatic write_range(input reg_index_t idx, input logic [SW-1:0] v);
    drain_items();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_RANGE_LOW) cur_low = v;
    else cur_high = v;
    @(negedge clk);
  endtask

  task automatic set_range(input logic [SW-1:0] lo, input logic [SW-1:0] hi);
    write_range(REG_RANGE_LOW, lo);
    write_range(REG_RANGE_HIGH, hi);
  endtask

  // Mostly samples inside x in [-1, 2) so the palette ramps get exercised,
  // the rest raw noise, samples right at the bounds and the sample extremes.
  function automatic logic [SW-1:0] pick_sample(input logic [SW-1:0] lo,
                                                input logic [SW-1:0] hi);
    int unsigned p;
    longint      span;
    longint      off;
    p    = $urandom_range(99);
    span = longint'($signed(hi)) - longint'($signed(lo));
    if (p < 70) begin
      off = (span * (longint'($urandom_range(3 * 65536 - 1)) - 65536)) >>> 16;
      return lo + off[SW-1:0];
    end else if (p < 85) begin
      return $urandom;
    end else if (p < 93) begin
      return ($urandom_range(1) ? hi : lo) + $urandom_range(4) - 2;
    end
    return $urandom_range(1) ? S_MIN : S_MAX;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset range 0..65536: x equals the sample in Q.16, including saturation
  // at both ends and the sample extremes.
  task automatic test_default_range();
    send_sample(0);
    send_sample(32768);
    send_sample(65535);
    send_sample(65536);
    send_sample(-1);
    send_sample(-65537);
    send_sample(131072);
    send_sample(S_MIN);
    send_sample(S_MAX);
  endtask

  // Range 0..1020 puts each palette breakpoint on an integer sample.
  task automatic test_palette_breakpoints();
    set_range(0, 1020);
    send_sample(-127);
    send_sample(133);
    send_sample(389);
    send_sample(392);
    send_sample(640);
    send_sample(644);
    send_sample(900);
    send_sample(1155);
  endtask

  // Empty and inverted ranges: all on above range_high, else all off.
  task automatic test_flat_ranges();
    set_range(5, 5);
    send_sample(5);
    send_sample(6);
    set_range(100, -100);
    send_sample(-100);
    send_sample(-99);
  endtask

  // Widest range: the divisor is 2^SW - 1.
  task automatic test_full_span();
    set_range(S_MIN, S_MAX);
    send_sample(S_MIN);
    send_sample(0);
    send_sample(S_MAX);
  endtask

  // Blocks of random items, each under a freshly written random range.
  task automatic test_random_traffic(input int idle_pct, input int n_items);
    int            sent;
    int            blk_len;
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          lo = S_MIN;
          hi = S_MAX;
        end
        1: begin
          lo = S_MAX;
          hi = S_MIN;
        end
        2: begin
          lo = $urandom;
          hi = lo;
        end
        3: begin
          hi = $urandom;
          lo = hi + ($urandom >> $urandom_range(31));
        end
        default: begin
          lo = $urandom;
          if ($urandom_range(1)) lo = $signed(lo) >>> $urandom_range(28);
          // Spans from one lsb to the full width; a wrap gives an inverted range.
          hi = lo + ($urandom >> $urandom_range(31)) + 1;
        end
      endcase
      if ($urandom_range(1)) begin
        set_range(lo, hi);
      end else begin
        write_range(REG_RANGE_HIGH, hi);
        write_range(REG_RANGE_LOW, lo);
      end
      blk_len = $urandom_range(20, 80);
      repeat (blk_len) begin
        send_sample(pick_sample(lo, hi));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done cycle must match the oldest owed color.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    color_item_t want;
    if (!rst && done) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d/%0d with no item pending",
                                  red, green, blue));
      end else begin
        want = pending_colors.pop_front();
        if (red !== want.color.r)
          report_mismatch($sformatf("sample %h: red %h, want %h",
                                    want.smp, red, want.color.r));
        if (green !== want.color.g)
          report_mismatch($sformatf("sample %h: green %h, want %h",
                                    want.smp, green, want.color.g));
        if (blue !== want.color.b)
          report_mismatch($sformatf("sample %h: blue %h, want %h",
                                    want.smp, blue, want.color.b));
      end
    end
  end

  // Watchdog: a long run of cycles with no item taken and no result means a hang.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    sample        = '0;
    wr_en         = 1'b0;
    wr_index      = REG_RANGE_LOW;
    wr_data       = '0;
    cur_low       = '0;
    cur_high      = 65536;
    send_idle_pct = 30;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_default_range();
    test_palette_breakpoints();
    test_flat_ranges();
    test_full_span();
    // Sender gaps 30%, then 48%, then back to back.
    test_random_traffic(30, 430);
    test_random_traffic(48, 430);
    test_random_traffic(0, 440);

    // Everything owed must arrive; then watch a while for stray results.
    drain_items();
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
